// ----- sv/tdf_pkg.sv -----
package tdf_pkg;

  // Field widths of a result word
  localparam int PRIME_W = 16;
  localparam int EXP_W   = 5;

  localparam int FIRST_DIVISOR = 2;

  // Microprogram counter
  localparam int PC_W = 4;

  typedef enum logic [3:0] {
    OP_NOP        = 4'd0,
    OP_LOAD       = 4'd1,
    OP_INIT_D     = 4'd2,
    OP_DIV_START  = 4'd3,
    OP_DIV_WAIT   = 4'd4,
    OP_CLR_E      = 4'd5,
    OP_INC_D      = 4'd6,
    OP_REDUCE     = 4'd7,
    OP_REC_D      = 4'd8,
    OP_REC_N      = 4'd9,
    OP_EMIT_LAST  = 4'd10,
    OP_EMIT_EMPTY = 4'd11
  } op_e;

  typedef enum logic [2:0] {
    COND_NONE   = 3'd0,
    COND_ALWAYS = 3'd1,
    COND_N_LT2  = 3'd2,
    COND_D_GT_Q = 3'd3,
    COND_R_Z    = 3'd4
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  // Step addresses
  localparam logic [PC_W-1:0] PC_LOAD      = 4'd0;
  localparam logic [PC_W-1:0] PC_INIT      = 4'd1;
  localparam logic [PC_W-1:0] PC_TRY       = 4'd2;
  localparam logic [PC_W-1:0] PC_TRY_WAIT  = 4'd3;
  localparam logic [PC_W-1:0] PC_BOUND     = 4'd4;
  localparam logic [PC_W-1:0] PC_HIT       = 4'd5;
  localparam logic [PC_W-1:0] PC_NEXT_D    = 4'd6;
  localparam logic [PC_W-1:0] PC_REDUCE    = 4'd7;
  localparam logic [PC_W-1:0] PC_RED_WAIT  = 4'd8;
  localparam logic [PC_W-1:0] PC_RED_TEST  = 4'd9;
  localparam logic [PC_W-1:0] PC_REC_D     = 4'd10;
  localparam logic [PC_W-1:0] PC_TAIL      = 4'd11;
  localparam logic [PC_W-1:0] PC_REC_N     = 4'd12;
  localparam logic [PC_W-1:0] PC_EMIT_LAST = 4'd13;
  localparam logic [PC_W-1:0] PC_EMPTY     = 4'd14;

  // Control store
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t uw;
    uw = '{op: OP_NOP, cond: COND_ALWAYS, target: PC_LOAD};
    unique case (pc)
      PC_LOAD:      uw = '{op: OP_LOAD,       cond: COND_NONE,   target: PC_LOAD};
      PC_INIT:      uw = '{op: OP_INIT_D,     cond: COND_N_LT2,  target: PC_EMPTY};
      PC_TRY:       uw = '{op: OP_DIV_START,  cond: COND_NONE,   target: PC_LOAD};
      PC_TRY_WAIT:  uw = '{op: OP_DIV_WAIT,   cond: COND_NONE,   target: PC_LOAD};
      PC_BOUND:     uw = '{op: OP_CLR_E,      cond: COND_D_GT_Q, target: PC_TAIL};
      PC_HIT:       uw = '{op: OP_NOP,        cond: COND_R_Z,    target: PC_REDUCE};
      PC_NEXT_D:    uw = '{op: OP_INC_D,      cond: COND_ALWAYS, target: PC_TRY};
      PC_REDUCE:    uw = '{op: OP_REDUCE,     cond: COND_NONE,   target: PC_LOAD};
      PC_RED_WAIT:  uw = '{op: OP_DIV_WAIT,   cond: COND_NONE,   target: PC_LOAD};
      PC_RED_TEST:  uw = '{op: OP_NOP,        cond: COND_R_Z,    target: PC_REDUCE};
      PC_REC_D:     uw = '{op: OP_REC_D,      cond: COND_ALWAYS, target: PC_TRY};
      PC_TAIL:      uw = '{op: OP_NOP,        cond: COND_N_LT2,  target: PC_EMIT_LAST};
      PC_REC_N:     uw = '{op: OP_REC_N,      cond: COND_NONE,   target: PC_LOAD};
      PC_EMIT_LAST: uw = '{op: OP_EMIT_LAST,  cond: COND_ALWAYS, target: PC_LOAD};
      PC_EMPTY:     uw = '{op: OP_EMIT_EMPTY, cond: COND_ALWAYS, target: PC_LOAD};
      default:      uw = '{op: OP_NOP,        cond: COND_ALWAYS, target: PC_LOAD};
    endcase
    return uw;
  endfunction

endpackage

// ----- sv/tdf_divider.sv -----
module tdf_divider #(
  parameter int WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             busy_o,
  output logic [WIDTH-1:0] quot_o,
  output logic [WIDTH-1:0] rem_o
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [WIDTH-1:0] quot_q, quot_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] dsr_q, dsr_d;

  logic [WIDTH:0] trial;
  logic [WIDTH:0] diff;
  logic           fits;

  // Restoring division, one quotient bit per cycle
  assign trial = {rem_q, quot_q[WIDTH-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(WIDTH);
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      quot_d = {quot_q[WIDTH-2:0], fits};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ----- sv/trial_division_factorizer_top.sv -----
// Channel  Direction  Handshake                   Word
// in       input      in_valid_i / in_stall_o     value_i
// out      output     out_valid_o / out_stall_i   prime_o, exponent_o, empty_res_o, last_o
//
// One word in at a time; the next is taken once the last result of the run is registered.
// Each trial divisor is one run of the one-bit-per-cycle remainder unit; an item takes
// roughly (floor(sqrt(value)) + sum of exponents) trials.
// Values below 2 give an empty result. Reset clears the sequencer and the output valid.
// A stalled output holds the sequencer at its next result; the input stalls meanwhile.
module trial_division_factorizer_top
  import tdf_pkg::*;
#(
  parameter int DATA_WIDTH          = 16,
  parameter int MAX_DISTINCT_PRIMES = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [DATA_WIDTH-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PRIME_W-1:0]    prime_o,
  output logic [EXP_W-1:0]      exponent_o,
  output logic                  empty_res_o,
  output logic                  last_o
);

  localparam int EW = $clog2(DATA_WIDTH);
  localparam int CW = $clog2(MAX_DISTINCT_PRIMES + 1);

  logic [PC_W-1:0]       pc_q, pc_d;
  logic [DATA_WIDTH-1:0] n_q, n_d;
  logic [DATA_WIDTH-1:0] d_q, d_d;
  logic [EW-1:0]         e_q, e_d;
  logic [CW-1:0]         count_q, count_d;
  logic [DATA_WIDTH-1:0] pend_prime_q, pend_prime_d;
  logic [EW-1:0]         pend_exp_q, pend_exp_d;

  logic                  out_valid_q, out_valid_d;
  logic [PRIME_W-1:0]    out_prime_q, out_prime_d;
  logic [EXP_W-1:0]      out_exp_q, out_exp_d;
  logic                  out_empty_q, out_empty_d;
  logic                  out_last_q, out_last_d;

  ucode_t                uw;
  logic                  hold;
  logic                  cond_true;
  logic                  out_free;
  logic                  out_push;
  logic                  rec_room;

  logic                  div_start;
  logic [DATA_WIDTH-1:0] div_dividend;
  logic                  div_busy;
  logic [DATA_WIDTH-1:0] div_quot;
  logic [DATA_WIDTH-1:0] div_rem;

  tdf_divider #(
    .WIDTH(DATA_WIDTH)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (d_q),
    .busy_o    (div_busy),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  assign uw       = ucode_rom(pc_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign rec_room = count_q < CW'(MAX_DISTINCT_PRIMES);

  always_comb begin
    unique case (uw.op)
      OP_LOAD:               hold = !in_valid_i;
      OP_DIV_WAIT:           hold = div_busy;
      OP_REC_D, OP_REC_N:    hold = rec_room && (count_q != '0) && !out_free;
      OP_EMIT_LAST,
      OP_EMIT_EMPTY:         hold = !out_free;
      default:               hold = 1'b0;
    endcase
  end

  always_comb begin
    unique case (uw.cond)
      COND_ALWAYS: cond_true = 1'b1;
      COND_N_LT2:  cond_true = n_q < DATA_WIDTH'(FIRST_DIVISOR);
      COND_D_GT_Q: cond_true = d_q > div_quot;
      COND_R_Z:    cond_true = div_rem == '0;
      default:     cond_true = 1'b0;
    endcase
  end

  assign div_start    = !hold && (uw.op == OP_DIV_START || uw.op == OP_REDUCE);
  assign div_dividend = (uw.op == OP_REDUCE) ? div_quot : n_q;
  assign in_stall_o   = pc_q != PC_LOAD;

  always_comb begin
    pc_d         = pc_q;
    n_d          = n_q;
    d_d          = d_q;
    e_d          = e_q;
    count_d      = count_q;
    pend_prime_d = pend_prime_q;
    pend_exp_d   = pend_exp_q;
    out_push     = 1'b0;
    out_prime_d  = out_prime_q;
    out_exp_d    = out_exp_q;
    out_empty_d  = out_empty_q;
    out_last_d   = out_last_q;

    if (!hold) begin
      pc_d = cond_true ? uw.target : pc_q + PC_W'(1);
      unique case (uw.op)
        OP_LOAD: begin
          n_d     = value_i;
          count_d = '0;
        end
        OP_INIT_D: d_d = DATA_WIDTH'(FIRST_DIVISOR);
        OP_CLR_E:  e_d = '0;
        OP_INC_D:  d_d = d_q + DATA_WIDTH'(1);
        OP_REDUCE: begin
          n_d = div_quot;
          e_d = e_q + EW'(1);
        end
        OP_REC_D, OP_REC_N: begin
          if (uw.op == OP_REC_D) begin
            d_d = d_q + DATA_WIDTH'(1);
          end
          if (rec_room) begin
            // push the pending factor out; the new one waits to learn if it ends the run
            if (count_q != '0) begin
              out_push    = 1'b1;
              out_prime_d = PRIME_W'(pend_prime_q);
              out_exp_d   = EXP_W'(pend_exp_q);
              out_empty_d = 1'b0;
              out_last_d  = 1'b0;
            end
            pend_prime_d = (uw.op == OP_REC_D) ? d_q : n_q;
            pend_exp_d   = (uw.op == OP_REC_D) ? e_q : EW'(1);
            count_d      = count_q + CW'(1);
          end
        end
        OP_EMIT_LAST: begin
          out_push    = 1'b1;
          out_prime_d = PRIME_W'(pend_prime_q);
          out_exp_d   = EXP_W'(pend_exp_q);
          out_empty_d = 1'b0;
          out_last_d  = 1'b1;
        end
        OP_EMIT_EMPTY: begin
          out_push    = 1'b1;
          out_prime_d = '0;
          out_exp_d   = '0;
          out_empty_d = 1'b1;
          out_last_d  = 1'b1;
        end
        default: ;
      endcase
    end

    if (out_push) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_LOAD;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q          <= n_d;
    d_q          <= d_d;
    e_q          <= e_d;
    pend_prime_q <= pend_prime_d;
    pend_exp_q   <= pend_exp_d;
    out_prime_q  <= out_prime_d;
    out_exp_q    <= out_exp_d;
    out_empty_q  <= out_empty_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign prime_o     = out_prime_q;
  assign exponent_o  = out_exp_q;
  assign empty_res_o = out_empty_q;
  assign last_o      = out_last_q;

`ifndef SYNTHESIS
  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> d_q >= DATA_WIDTH'(FIRST_DIVISOR))
    else $error("trial divisor below two");

  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> out_free)
    else $error("output word overwritten while stalled");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_empty_q) |-> out_last_q)
    else $error("empty result not marked last");
`endif

endmodule
